@@ sv/gnss_response_frame_receiver_macros.svh @@
// Assertion macros for the response frame receiver.
`ifndef GNSS_RESPONSE_FRAME_RECEIVER_MACROS_SVH
`define GNSS_RESPONSE_FRAME_RECEIVER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, a, b)
`define ASSERT_NEXT(lbl, a, b)
`endif
`endif

@@ sv/grfr_pkg.sv @@
// Types and constants of the response frame receiver.
package grfr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HUNT    = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAILER = 3'd5
  } phase_t;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_ARM  = 2'd2;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  localparam logic [1:0] CFG_TIMEOUT     = 2'd0;
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd1;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET     = 16'd1000;
  localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hA0;
  localparam logic [7:0]  SYNC_SECOND_RESET = 8'hA1;

  localparam logic [15:0] TRAILER_BYTES = 16'd3;
  localparam logic [16:0] ELAPSED_MAX   = 17'h1FFFF;

endpackage

@@ sv/gnss_response_frame_receiver.sv @@
// Top level of the length-prefixed response frame receiver.
//
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  in      | in_valid, in_ready, mode, rx_byte         | in
//  out     | out_valid, out_ready, kind, data_byte,    | out
//          | reported_count, last                      |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One item per cycle sustained while the output is not stalled; a result goes
// through the input register, then the result register, to the output.
// The next-state logic for the phase and timer decides the rate: one pass.
// rst is synchronous: phase idle, counters zero, registers at reset values.
// A stalled output holds the input stage; in_ready is high while the stage is empty or advancing.
// cfg_ready is always high; indexes beyond the list are ignored.
module gnss_response_frame_receiver
  import grfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [16:0] reported_count,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  `include "gnss_response_frame_receiver_macros.svh"

  logic [15:0] timeout_ticks;
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;

  logic        stage_valid;
  logic [1:0]  stage_mode;
  logic [7:0]  stage_byte;

  phase_t      phase, phase_next;
  logic [7:0]  previous_byte, previous_byte_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [16:0] elapsed_ticks, elapsed_ticks_next;

  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_data;
  logic [16:0] res_count;
  logic        res_last;

  logic        advance;
  logic [16:0] elapsed_inc;
  logic [16:0] timeout_ext;
  logic [15:0] seen_inc;
  logic [15:0] len_merged;

  assign advance   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || advance;
  assign cfg_ready = 1'b1;

  assign timeout_ext = {1'b0, timeout_ticks};
  assign elapsed_inc = (elapsed_ticks == ELAPSED_MAX) ? elapsed_ticks
                                                      : elapsed_ticks + 17'd1;
  assign seen_inc    = bytes_seen + 16'd1;
  assign len_merged  = frame_length | {8'h00, stage_byte};

  always_comb begin
    phase_next         = phase;
    previous_byte_next = previous_byte;
    frame_length_next  = frame_length;
    bytes_seen_next    = bytes_seen;
    elapsed_ticks_next = elapsed_ticks;
    res_valid          = 1'b0;
    res_kind           = KIND_DATA;
    res_data           = 8'h00;
    res_count          = 17'd0;
    res_last           = 1'b0;
    case (stage_mode)
      MODE_ARM: begin
        previous_byte_next = 8'h00;
        frame_length_next  = 16'h0000;
        bytes_seen_next    = 16'h0000;
        elapsed_ticks_next = 17'd0;
        phase_next         = PH_HUNT;
      end
      MODE_TICK: begin
        if (phase != PH_IDLE) begin
          elapsed_ticks_next = elapsed_inc;
          // hunt fails on reaching the limit, later phases on passing it
          if ((phase == PH_HUNT) ? (elapsed_inc >= timeout_ext)
                                 : (elapsed_inc > timeout_ext)) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res_kind   = KIND_TIMEOUT;
            res_last   = 1'b1;
          end
        end
      end
      MODE_BYTE: begin
        case (phase)
          PH_HUNT: begin
            if (elapsed_ticks >= timeout_ext) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res_kind   = KIND_TIMEOUT;
              res_last   = 1'b1;
            end else if (stage_byte == sync_second && previous_byte == sync_first) begin
              phase_next         = PH_LEN_HI;
              elapsed_ticks_next = 17'd0;
            end else begin
              previous_byte_next = stage_byte;
            end
          end
          PH_LEN_HI: begin
            frame_length_next = {stage_byte, 8'h00};
            phase_next        = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            frame_length_next  = len_merged;
            bytes_seen_next    = 16'h0000;
            elapsed_ticks_next = 17'd0;
            phase_next         = (len_merged == 16'h0000) ? PH_TRAILER : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            bytes_seen_next = seen_inc;
            if (seen_inc >= frame_length) begin
              bytes_seen_next = 16'h0000;
              phase_next      = PH_TRAILER;
            end
            res_valid = 1'b1;
            res_kind  = KIND_DATA;
            res_data  = stage_byte;
          end
          PH_TRAILER: begin
            // checksum and end bytes are counted, not checked
            bytes_seen_next = seen_inc;
            if (seen_inc >= TRAILER_BYTES) begin
              bytes_seen_next = 16'h0000;
              phase_next      = PH_IDLE;
              res_valid       = 1'b1;
              res_kind        = KIND_DONE;
              res_count       = {1'b0, frame_length} + 17'd1;
              res_last        = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      sync_first    <= SYNC_FIRST_RESET;
      sync_second   <= SYNC_SECOND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIMEOUT:     timeout_ticks <= cfg_data;
        CFG_SYNC_FIRST:  sync_first    <= cfg_data[7:0];
        CFG_SYNC_SECOND: sync_second   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      stage_mode <= mode;
      stage_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      previous_byte <= 8'h00;
      frame_length  <= 16'h0000;
      bytes_seen    <= 16'h0000;
      elapsed_ticks <= 17'd0;
    end else if (advance) begin
      phase         <= phase_next;
      previous_byte <= previous_byte_next;
      frame_length  <= frame_length_next;
      bytes_seen    <= bytes_seen_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && res_valid) begin
      kind           <= res_kind;
      data_byte      <= res_data;
      reported_count <= res_count;
      last           <= res_last;
    end
  end

  `ASSERT_IMPL(a_end_is_last, out_valid && kind != KIND_DATA, last)
  `ASSERT_IMPL(a_data_no_count, out_valid && kind == KIND_DATA, reported_count == 17'd0 && !last)
  `ASSERT_NEXT(a_last_goes_idle, advance && res_valid && res_last, phase == PH_IDLE)
  `ASSERT_IMPL(a_trailer_bound, phase == PH_TRAILER, bytes_seen < TRAILER_BYTES)
  `ASSERT_NEXT(a_stall_holds_stage, stage_valid && !advance, stage_valid && $stable(stage_mode))

endmodule
